FILE: rtl/srt_pkg.sv
// Shared types, codes and defaults for the ranked score table.
package srt_pkg;

  localparam int LIST_DEPTH_DEF = 8;
  localparam int NAME_CHARS_DEF = 8;
  localparam int NUM_LISTS_DEF  = 4;

  localparam int REQ_W    = 2;
  localparam int LIST_W   = 2;
  localparam int INDEX_W  = 3;
  localparam int POINTS_W = 16;
  localparam int NAME_W   = 64;
  localparam int COUNT_W  = 4;

  localparam logic [7:0] EMPTY_CHAR = 8'h2D;  // '-'
  localparam logic [7:0] BLANK_CHAR = 8'h20;  // ' '

  typedef enum logic [REQ_W-1:0] {
    REQ_SAVE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_LAST  = 2'd2,
    REQ_COUNT = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SH_RD,
    ST_SH_WR,
    ST_WR_NEW,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

endpackage

FILE: rtl/srt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ranked_score_table.sv
// Ranked score table: several sorted top-k lists of points and names in one RAM.
// Requests answered without the RAM (bad list, bad index, no save yet) are answered from
// IDLE; a read passes RD_ADDR and RD_DATA; a count or a rejected save scans every rank
// of the list; a save scans, then reads and writes once per shifted entry, then writes.
// Flow: one request at a time; busy drops in the result strobe cycle, so the next beat
// can be taken in that cycle; requests answered without the RAM leave busy low.
// Reset: clears every RAM entry, one entry a cycle, with busy high.
module ranked_score_table #(
  parameter int LIST_DEPTH = srt_pkg::LIST_DEPTH_DEF,
  parameter int NAME_CHARS = srt_pkg::NAME_CHARS_DEF,
  parameter int NUM_LISTS  = srt_pkg::NUM_LISTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [srt_pkg::REQ_W-1:0]     in_req_type,
  input  logic [srt_pkg::LIST_W-1:0]    in_list_select,
  input  logic [srt_pkg::INDEX_W-1:0]   in_entry_index,
  input  logic [srt_pkg::POINTS_W-1:0]  in_points_in,
  input  logic [srt_pkg::NAME_W-1:0]    in_name_in,
  output logic                          out_valid,
  output logic [srt_pkg::POINTS_W-1:0]  out_points_out,
  output logic [srt_pkg::NAME_W-1:0]    out_name_out,
  output logic [srt_pkg::COUNT_W-1:0]   out_count_out,
  output logic                          out_rejected
);

  import srt_pkg::*;

  localparam int SLOTS   = NUM_LISTS * LIST_DEPTH;
  localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RANK_W  = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W   = $clog2(LIST_DEPTH);
  localparam int NM_W    = 8 * NAME_CHARS;
  localparam int ENTRY_W = POINTS_W + NM_W;

  // Slot address of a rank inside a list.
  function automatic logic [ADDR_W-1:0] slot_of(logic [LIST_W-1:0] lst,
                                                 logic [RANK_W-1:0] rk);
    slot_of = ADDR_W'(32'(lst) * LIST_DEPTH + 32'(rk));
  endfunction

  // Show empty characters as '-'.
  function automatic logic [NM_W-1:0] show_name(logic [NM_W-1:0] raw);
    logic [NM_W-1:0] res;
    res = raw;
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (raw[8*i +: 8] == 8'h00) begin
        res[8*i +: 8] = EMPTY_CHAR;
      end
    end
    return res;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_count(logic [RANK_W-1:0] c);
    return (8'(c) > 8'd15) ? 4'd15 : 4'(c);
  endfunction

  localparam logic [NM_W-1:0] BLANK_NAME = {NAME_CHARS{BLANK_CHAR}};

  // Control state
  state_t                state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_r, clr_nxt;
  logic [RANK_W-1:0]     scan_r, scan_nxt;     // next rank to read during the scan
  logic                  rd_pend_r, rd_pend_nxt;
  logic [RANK_W-1:0]     cnt_r, cnt_nxt;       // entries at or above the request points
  logic [RANK_W-1:0]     sh_r, sh_nxt;         // destination rank of the shift
  logic [LIST_W-1:0]     last_list_r, last_list_nxt;
  logic [IDX_W-1:0]      last_rank_r, last_rank_nxt;
  logic                  any_saved_r, any_saved_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Latched request beat
  req_t                  req_r, req_nxt;
  logic [LIST_W-1:0]     list_r, list_nxt;
  logic [INDEX_W-1:0]    idx_r, idx_nxt;
  logic [POINTS_W-1:0]   pts_r, pts_nxt;
  logic [NM_W-1:0]       name_r, name_nxt;

  // Result beat
  logic [POINTS_W-1:0]   out_points_r, out_points_nxt;
  logic [NAME_W-1:0]     out_name_r, out_name_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;
  logic                  out_rej_r, out_rej_nxt;

  // RAM port
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;

  // Decode of the incoming beat and of progress
  logic                  accept;
  logic                  list_ok_in;
  logic                  idx_ok_in;
  logic                  quick_in;
  logic                  scan_done;
  logic                  clr_done;
  logic [RANK_W-1:0]     sh_prev;
  logic [POINTS_W-1:0]   rd_points;
  logic [NM_W-1:0]       rd_name;

  assign accept     = start && !busy;
  assign list_ok_in = 5'(in_list_select) < 5'(NUM_LISTS);
  assign idx_ok_in  = 7'(in_entry_index) < 7'(LIST_DEPTH);
  assign scan_done  = (scan_r == RANK_W'(LIST_DEPTH)) && !rd_pend_r;
  assign clr_done   = (clr_r == ADDR_W'(SLOTS - 1));
  assign sh_prev    = sh_r - RANK_W'(1);
  assign rd_points  = ram_rdata[NM_W +: POINTS_W];
  assign rd_name    = ram_rdata[NM_W-1:0];

  // Requests answered straight from the request and the control registers.
  always_comb begin
    case (req_t'(in_req_type))
      REQ_SAVE:  quick_in = !list_ok_in;
      REQ_READ:  quick_in = !(list_ok_in && idx_ok_in);
      REQ_LAST:  quick_in = !any_saved_r;
      default:   quick_in = !list_ok_in;
    endcase
  end

  srt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && !quick_in) begin
          if (req_t'(in_req_type) == REQ_SAVE || req_t'(in_req_type) == REQ_COUNT) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RD_ADDR;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (req_r == REQ_COUNT || 32'(cnt_r) >= LIST_DEPTH) begin
            state_nxt = ST_IDLE;
          end else if (RANK_W'(LIST_DEPTH - 1) > cnt_r) begin
            state_nxt = ST_SH_RD;
          end else begin
            state_nxt = ST_WR_NEW;
          end
        end
      end
      ST_SH_RD:   state_nxt = ST_SH_WR;
      ST_SH_WR:   state_nxt = (sh_prev > cnt_r) ? ST_SH_RD : ST_WR_NEW;
      ST_WR_NEW:  state_nxt = ST_IDLE;
      ST_RD_ADDR: state_nxt = ST_RD_DATA;
      ST_RD_DATA: state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, RAM control and result beat
  always_comb begin
    clr_nxt        = clr_r;
    scan_nxt       = scan_r;
    rd_pend_nxt    = 1'b0;
    cnt_nxt        = cnt_r;
    sh_nxt         = sh_r;
    last_list_nxt  = last_list_r;
    last_rank_nxt  = last_rank_r;
    any_saved_nxt  = any_saved_r;
    req_nxt        = req_r;
    list_nxt       = list_r;
    idx_nxt        = idx_r;
    pts_nxt        = pts_r;
    name_nxt       = name_r;
    out_valid_nxt  = 1'b0;
    out_points_nxt = out_points_r;
    out_name_nxt   = out_name_r;
    out_count_nxt  = out_count_r;
    out_rej_nxt    = out_rej_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    unique case (state_r)
      ST_CLEAR: begin
        // zero one entry a cycle
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          req_nxt  = req_t'(in_req_type);
          list_nxt = in_list_select;
          idx_nxt  = in_entry_index;
          pts_nxt  = in_points_in;
          name_nxt = in_name_in[NM_W-1:0];
          cnt_nxt  = '0;
          scan_nxt = '0;
          if (quick_in) begin
            out_valid_nxt  = 1'b1;
            out_points_nxt = '0;
            out_count_nxt  = '0;
            out_rej_nxt    = (req_t'(in_req_type) == REQ_SAVE);
            out_name_nxt   = (req_t'(in_req_type) == REQ_LAST) ? NAME_W'(BLANK_NAME) : '0;
          end
        end
      end
      ST_SCAN: begin
        // issue one rank a cycle, compare the beat read the cycle before
        if (32'(scan_r) < LIST_DEPTH) begin
          ram_raddr   = slot_of(list_r, scan_r);
          scan_nxt    = scan_r + RANK_W'(1);
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r && rd_points >= pts_r) begin
          cnt_nxt = cnt_r + RANK_W'(1);
        end
        if (scan_done) begin
          sh_nxt = RANK_W'(LIST_DEPTH - 1);
          if (req_r == REQ_COUNT || 32'(cnt_r) >= LIST_DEPTH) begin
            out_valid_nxt  = 1'b1;
            out_points_nxt = '0;
            out_name_nxt   = '0;
            out_count_nxt  = sat_count(cnt_r);
            out_rej_nxt    = (req_r == REQ_SAVE);
          end
        end
      end
      ST_SH_RD: begin
        ram_raddr = slot_of(list_r, sh_prev);
      end
      ST_SH_WR: begin
        // move the entry above down one rank
        ram_we    = 1'b1;
        ram_waddr = slot_of(list_r, sh_r);
        ram_wdata = ram_rdata;
        sh_nxt    = sh_prev;
      end
      ST_WR_NEW: begin
        ram_we         = 1'b1;
        ram_waddr      = slot_of(list_r, cnt_r);
        ram_wdata      = {pts_r, name_r};
        last_list_nxt  = list_r;
        last_rank_nxt  = IDX_W'(cnt_r);
        any_saved_nxt  = 1'b1;
        out_valid_nxt  = 1'b1;
        out_points_nxt = '0;
        out_name_nxt   = '0;
        out_count_nxt  = sat_count(cnt_r);
        out_rej_nxt    = 1'b0;
      end
      ST_RD_ADDR: begin
        if (req_r == REQ_LAST) begin
          ram_raddr = slot_of(last_list_r, RANK_W'(last_rank_r));
        end else begin
          ram_raddr = slot_of(list_r, RANK_W'(idx_r));
        end
      end
      ST_RD_DATA: begin
        out_valid_nxt = 1'b1;
        out_count_nxt = '0;
        out_rej_nxt   = 1'b0;
        if (req_r == REQ_READ) begin
          out_points_nxt = rd_points;
          out_name_nxt   = NAME_W'(show_name(rd_name));
        end else begin
          out_points_nxt = '0;
          out_name_nxt   = NAME_W'(rd_name);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      scan_r      <= '0;
      rd_pend_r   <= 1'b0;
      cnt_r       <= '0;
      sh_r        <= '0;
      last_list_r <= '0;
      last_rank_r <= '0;
      any_saved_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      scan_r      <= scan_nxt;
      rd_pend_r   <= rd_pend_nxt;
      cnt_r       <= cnt_nxt;
      sh_r        <= sh_nxt;
      last_list_r <= last_list_nxt;
      last_rank_r <= last_rank_nxt;
      any_saved_r <= any_saved_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    list_r       <= list_nxt;
    idx_r        <= idx_nxt;
    pts_r        <= pts_nxt;
    name_r       <= name_nxt;
    out_points_r <= out_points_nxt;
    out_name_r   <= out_name_nxt;
    out_count_r  <= out_count_nxt;
    out_rej_r    <= out_rej_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_points_out = out_points_r;
  assign out_name_out   = out_name_r;
  assign out_count_out  = out_count_r;
  assign out_rejected   = out_rej_r;

endmodule
